// File: rtl/aors_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aors_pkg
// Shared types and constants for the append-only record slot store.
// ----------------------------------------------------------------------------
package aors_pkg;

  localparam int SLOTS        = 32;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] STAMP_EMPTY = 32'hFFFF_FFFF;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NODATA  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_UP,
    S_ERASE,
    S_WRITE,
    S_SCAN_DOWN,
    S_FETCH,
    S_DATA
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic [31:0]             stamp;
    logic [PAYLOAD_BITS-1:0] payload;
  } rec_t;

endpackage
`default_nettype wire

// File: rtl/aors_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aors_mem
// Record slot memory: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module aors_mem (
  input  wire               clk,
  input  aors_pkg::mem_req_t req,
  input  aors_pkg::rec_t     wdata,
  output aors_pkg::rec_t     rdata
);
  import aors_pkg::*;

  rec_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/append_only_record_slot_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// append_only_record_slot_store
// Page of record slots: appends to the first empty slot, erases the page when
// full, reads the latest record or a named slot.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  command   start / busy        action, has_constants, stamp_in, payload_in,
//                                read_latest, read_slot
//  result    done (one cycle)    status, slot_used, page_erased, stamp_out,
//                                payload_out
//
//  a write walks the slot occupancy bits one per cycle from slot 0, erases
//  the page if no slot is empty, then writes the record; a latest read walks
//  down from the top slot and then fetches the record; a named read fetches
//  its slot directly, and rejected writes and missing named reads finish from idle.
//  reset clears all occupancy bits at once, so every slot reads as empty.
//  busy is high while an item is worked on; done pulses once per item and
//  cannot be held off.
// ----------------------------------------------------------------------------
module append_only_record_slot_store (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         action,
  input  wire         has_constants,
  input  wire  [31:0] stamp_in,
  input  wire  [63:0] payload_in,
  input  wire         read_latest,
  input  wire  [7:0]  read_slot,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  slot_used,
  output logic        page_erased,
  output logic [31:0] stamp_out,
  output logic [63:0] payload_out
);
  import aors_pkg::*;

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  state_t            state, state_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic [SLOTS-1:0]  full;
  logic [31:0]       stamp_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic              erased;

  logic              accept;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic              finish;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_erased;
  logic              res_data;
  logic              do_erase;
  logic              do_fill;
  mem_req_t          req;
  rec_t              wdata;
  rec_t              rdata;

  assign accept   = start && !busy;
  assign slot_ok  = (32'(read_slot) < SLOTS);
  assign slot_idx = read_slot[SLOT_W-1:0];
  assign wdata    = '{stamp: stamp_r, payload: payload_r};
  assign busy     = (state != S_IDLE);

  aors_mem u_mem (
    .clk   (clk),
    .req   (req),
    .wdata (wdata),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_WRITE) begin
            state_next = has_constants ? S_SCAN_UP : S_IDLE;
          end else if (read_latest) begin
            state_next = S_SCAN_DOWN;
          end else if (slot_ok && full[slot_idx]) begin
            state_next = S_FETCH;
          end
        end
      end
      S_SCAN_UP: begin
        if (!full[idx]) begin
          state_next = S_WRITE;
        end else if (idx == LAST) begin
          state_next = S_ERASE;
        end
      end
      S_ERASE:     state_next = S_WRITE;
      S_WRITE:     state_next = S_IDLE;
      S_SCAN_DOWN: begin
        if (full[idx]) begin
          state_next = S_FETCH;
        end else if (idx == '0) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH:     state_next = S_DATA;
      S_DATA:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    idx_next   = idx;
    finish     = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_erased = 1'b0;
    res_data   = 1'b0;
    do_erase   = 1'b0;
    do_fill    = 1'b0;
    req        = '{we: 1'b0, re: 1'b0, addr: idx};
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_WRITE) begin
            idx_next = '0;
            if (!has_constants) begin
              finish     = 1'b1;
              res_status = ST_INVALID;
            end
          end else if (read_latest) begin
            idx_next = LAST;
          end else begin
            idx_next = slot_idx;
            if (!(slot_ok && full[slot_idx])) begin
              finish     = 1'b1;
              res_status = ST_NODATA;
            end
          end
        end
      end
      S_SCAN_UP: begin
        if (full[idx] && idx != LAST) begin
          idx_next = idx + 1'b1;
        end
      end
      S_ERASE: begin
        do_erase = 1'b1;
        idx_next = '0;
      end
      S_WRITE: begin
        req.we     = 1'b1;
        do_fill    = 1'b1;
        finish     = 1'b1;
        res_slot   = idx;
        res_erased = erased;
      end
      S_SCAN_DOWN: begin
        if (!full[idx]) begin
          if (idx == '0) begin
            finish     = 1'b1;
            res_status = ST_NODATA;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      S_FETCH: begin
        req.re = 1'b1;
      end
      S_DATA: begin
        finish   = 1'b1;
        res_slot = idx;
        res_data = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      full   <= '0;
      erased <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        erased <= 1'b0;
      end else if (do_erase) begin
        erased <= 1'b1;
      end
      if (do_erase) begin
        full <= '0;
      end else if (do_fill) begin
        // an all-ones stamp is stored but the slot stays empty
        full[idx] <= (stamp_r != STAMP_EMPTY);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      stamp_r   <= stamp_in;
      payload_r <= payload_in[PAYLOAD_BITS-1:0];
    end
    if (finish) begin
      status      <= res_status;
      slot_used   <= 8'(res_slot);
      page_erased <= res_erased;
      stamp_out   <= res_data ? rdata.stamp : '0;
      payload_out <= res_data ? 64'(rdata.payload) : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/aors_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aors_checker
// Port-level checks on the record slot store, bound to the top level.
// ----------------------------------------------------------------------------
module aors_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [1:0]  status,
  input wire [7:0]  slot_used,
  input wire        page_erased,
  input wire [31:0] stamp_out,
  input wire [63:0] payload_out
);
  import aors_pkg::*;

  // an accepted item either keeps the block busy or ends at once
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither raised busy nor finished");

  // a result only ends work that was under way or just taken
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without an item in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_INVALID || status == ST_NODATA))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (slot_used == 8'd0 && !page_erased && stamp_out == 32'd0 && payload_out == 64'd0))
    else $error("failed item carries nonzero fields");

  // an erase only accompanies a successful write, which returns no data
  a_erase_write: assert property (@(posedge clk) disable iff (rst)
    (done && page_erased) |->
      (status == ST_OK && slot_used == 8'd0 && stamp_out == 32'd0 && payload_out == 64'd0))
    else $error("page erase reported outside a write to slot zero");

endmodule

bind append_only_record_slot_store aors_checker u_aors_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .slot_used   (slot_used),
  .page_erased (page_erased),
  .stamp_out   (stamp_out),
  .payload_out (payload_out)
);
`default_nettype wire

// File: sim/tb_append_only_record_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_append_only_record_slot_store
// Self-checking bench for the record slot store. An opening table covers
// empty-page reads, rejected writes, the all-ones stamp, range limits and
// extreme stamp and payload values. A long random run of mostly valid writes
// follows, so the page fills and is erased many times, mixed with latest
// reads, named reads and invalid writes. A page model in the bench predicts
// each result not given by a table row; results are compared field by field.
// ----------------------------------------------------------------------------
module tb_append_only_record_slot_store;
  import aors_pkg::*;

  localparam int OPENING_ROWS = 18;
  localparam int RANDOM_ITEMS = 1932;
  localparam int TAIL_ITEMS   = 150;
  localparam int SETTLE       = SLOTS + 8;

  typedef struct packed {
    logic        action;
    logic        has_constants;
    logic [31:0] stamp;
    logic [63:0] payload;
    logic        latest;
    logic [7:0]  slot;
  } record_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic        erased;
    logic [31:0] stamp;
    logic [63:0] payload;
  } record_result_t;

  typedef struct packed {
    record_cmd_t    cmd;
    logic           typed;
    record_result_t want;
  } opening_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic        action        = ACT_WRITE;
  logic        has_constants = 1'b0;
  logic [31:0] stamp_in      = '0;
  logic [63:0] payload_in    = '0;
  logic        read_latest   = 1'b0;
  logic [7:0]  read_slot     = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  slot_used;
  logic        page_erased;
  logic [31:0] stamp_out;
  logic [63:0] payload_out;

  logic [31:0]             page_stamp   [SLOTS];
  logic [PAYLOAD_BITS-1:0] page_payload [SLOTS];
  record_result_t          pending_results [$];
  record_result_t          oldest_want;
  opening_row_t            opening_rows [OPENING_ROWS];
  int                      mismatches = 0;

  append_only_record_slot_store dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .has_constants (has_constants),
    .stamp_in      (stamp_in),
    .payload_in    (payload_in),
    .read_latest   (read_latest),
    .read_slot     (read_slot),
    .done          (done),
    .status        (status),
    .slot_used     (slot_used),
    .page_erased   (page_erased),
    .stamp_out     (stamp_out),
    .payload_out   (payload_out)
  );

  always #6 clk = ~clk;

  task automatic flag_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // page model: advances the slot contents and returns the expected result
  function automatic record_result_t apply_to_page(record_cmd_t c);
    record_result_t r;
    int             idx;
    int             i;
    bit             found;
    r     = '0;
    idx   = 0;
    found = 1'b0;
    if (c.action == ACT_WRITE) begin
      if (!c.has_constants) begin
        r.status = ST_INVALID;
      end else begin
        idx = SLOTS;
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (page_stamp[i] == STAMP_EMPTY) idx = i;
        end
        if (idx == SLOTS) begin
          for (i = 0; i < SLOTS; i++) begin
            page_stamp[i]   = STAMP_EMPTY;
            page_payload[i] = '1;
          end
          idx      = 0;
          r.erased = 1'b1;
        end
        page_stamp[idx]   = c.stamp;
        page_payload[idx] = c.payload[PAYLOAD_BITS-1:0];
        r.status          = ST_OK;
        r.slot            = idx[7:0];
      end
    end else begin
      if (c.latest) begin
        for (i = 0; i < SLOTS; i++) begin
          if (page_stamp[i] != STAMP_EMPTY) begin
            idx   = i;
            found = 1'b1;
          end
        end
      end else if (c.slot < SLOTS) begin
        idx   = int'(c.slot);
        found = (page_stamp[idx] != STAMP_EMPTY);
      end
      if (found) begin
        r.status                     = ST_OK;
        r.slot                       = idx[7:0];
        r.stamp                      = page_stamp[idx];
        r.payload[PAYLOAD_BITS-1:0]  = page_payload[idx];
      end else begin
        r.status = ST_NODATA;
      end
    end
    return r;
  endfunction

  // unused fields of a command carry random junk
  function automatic record_cmd_t mk_write(logic hc, logic [31:0] st, logic [63:0] pl);
    record_cmd_t c;
    c.action        = ACT_WRITE;
    c.has_constants = hc;
    c.stamp         = st;
    c.payload       = pl;
    c.latest        = 1'($urandom_range(1));
    c.slot          = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic record_cmd_t mk_read(logic latest, logic [7:0] slot);
    record_cmd_t c;
    c.action        = ACT_READ;
    c.has_constants = 1'($urandom_range(1));
    c.stamp         = $urandom;
    c.payload       = {$urandom, $urandom};
    c.latest        = latest;
    c.slot          = slot;
    return c;
  endfunction

  function automatic record_result_t res(status_t s, logic [7:0] sl, logic er,
                                         logic [31:0] st, logic [63:0] pl);
    record_result_t r;
    r.status  = s;
    r.slot    = sl;
    r.erased  = er;
    r.stamp   = st;
    r.payload = pl;
    return r;
  endfunction

  function automatic opening_row_t row(record_cmd_t c, logic typed, record_result_t w);
    opening_row_t o;
    o.cmd   = c;
    o.typed = typed;
    o.want  = w;
    return o;
  endfunction

  function automatic record_cmd_t random_cmd();
    record_cmd_t c;
    int          pick;
    int          flavor;
    pick   = $urandom_range(99);
    flavor = $urandom_range(19);
    c      = mk_write(1'b1, $urandom, {$urandom, $urandom});
    case (flavor)
      0: c.stamp = STAMP_EMPTY;
      1: c.stamp = 32'h0000_0000;
      2: c.stamp = 32'h7FFF_FFFF;
      3: c.stamp = 32'h8000_0000;
      default: ;
    endcase
    if (pick >= 62 && pick < 67) begin
      c.has_constants = 1'b0;
    end else if (pick >= 67 && pick < 80) begin
      c = mk_read(1'b1, 8'($urandom_range(255)));
    end else if (pick >= 80 && pick < 95) begin
      c = mk_read(1'b0, 8'($urandom_range(SLOTS - 1)));
    end else if (pick >= 95) begin
      c = mk_read(1'b0, 8'($urandom_range(255)));
    end
    return c;
  endfunction

  // call right after a rising edge; returns at the edge that takes the item
  task automatic send_record_cmd(record_cmd_t c, logic typed, record_result_t want);
    record_result_t pred;
    start         <= 1'b1;
    action        <= c.action;
    has_constants <= c.has_constants;
    stamp_in      <= c.stamp;
    payload_in    <= c.payload;
    read_latest   <= c.latest;
    read_slot     <= c.slot;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pred = apply_to_page(c);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_error("result with no item outstanding");
      end else begin
        oldest_want = pending_results.pop_front();
        check_field("status", 64'(status), 64'(oldest_want.status));
        check_field("slot_used", 64'(slot_used), 64'(oldest_want.slot));
        check_field("page_erased", 64'(page_erased), 64'(oldest_want.erased));
        check_field("stamp_out", 64'(stamp_out), 64'(oldest_want.stamp));
        check_field("payload_out", payload_out, oldest_want.payload);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL append_only_record_slot_store");
    $finish;
  end

  initial begin
    int n;
    int guard;
    for (n = 0; n < SLOTS; n++) begin
      page_stamp[n]   = STAMP_EMPTY;
      page_payload[n] = '0;
    end

    opening_rows[0]  = row(mk_read(1'b1, 8'd0), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[1]  = row(mk_read(1'b0, 8'd0), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[2]  = row(mk_write(1'b0, 32'h7FFF_FFFF, '1), 1'b1,
                           res(ST_INVALID, 0, 0, 0, 0));
    opening_rows[3]  = row(mk_write(1'b1, 32'h7FFF_FFFF, '1), 1'b1,
                           res(ST_OK, 0, 0, 0, 0));
    opening_rows[4]  = row(mk_write(1'b1, 32'h8000_0000, '0), 1'b1,
                           res(ST_OK, 1, 0, 0, 0));
    // all-ones stamp is stored but the slot stays empty
    opening_rows[5]  = row(mk_write(1'b1, STAMP_EMPTY, 64'h0123_4567_89AB_CDEF), 1'b1,
                           res(ST_OK, 2, 0, 0, 0));
    opening_rows[6]  = row(mk_read(1'b0, 8'd2), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[7]  = row(mk_write(1'b1, 32'h0, 64'hA5A5_5A5A_A5A5_5A5A), 1'b1,
                           res(ST_OK, 2, 0, 0, 0));
    opening_rows[8]  = row(mk_read(1'b1, 8'd0), 1'b1,
                           res(ST_OK, 2, 0, 32'h0, 64'hA5A5_5A5A_A5A5_5A5A));
    opening_rows[9]  = row(mk_read(1'b0, 8'd0), 1'b1,
                           res(ST_OK, 0, 0, 32'h7FFF_FFFF, '1));
    opening_rows[10] = row(mk_read(1'b0, 8'd1), 1'b1,
                           res(ST_OK, 1, 0, 32'h8000_0000, '0));
    opening_rows[11] = row(mk_read(1'b0, 8'(SLOTS - 1)), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[12] = row(mk_read(1'b0, 8'(SLOTS)), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[13] = row(mk_read(1'b0, 8'hFF), 1'b1, res(ST_NODATA, 0, 0, 0, 0));
    opening_rows[14] = row(mk_write(1'b0, STAMP_EMPTY, '0), 1'b1,
                           res(ST_INVALID, 0, 0, 0, 0));
    opening_rows[15] = row(mk_write(1'b1, $urandom, {$urandom, $urandom}), 1'b0, '0);
    // latest read ignores the slot number
    opening_rows[16] = row(mk_read(1'b1, 8'hFF), 1'b0, '0);
    opening_rows[17] = row(mk_read(1'b0, 8'd3), 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < OPENING_ROWS; n++) begin
      send_record_cmd(opening_rows[n].cmd, opening_rows[n].typed, opening_rows[n].want);
    end
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_record_cmd(random_cmd(), 1'b0, '0);
      if (n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end

    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 4 * SETTLE) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    while (pending_results.size() != 0) begin
      oldest_want = pending_results.pop_front();
      flag_error($sformatf("no result for item expecting status %0d slot %0d",
                           oldest_want.status, oldest_want.slot));
    end

    if (mismatches == 0) begin
      $display("PASS append_only_record_slot_store");
    end else begin
      $display("FAIL append_only_record_slot_store");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/aors_pkg.sv
rtl/aors_mem.sv
rtl/append_only_record_slot_store.sv
rtl/aors_checker.sv
sim/tb_append_only_record_slot_store.sv
